### src/gsw_pkg.sv
// shared types and constants for the gaussian / sobel window filter
`default_nettype none
package gsw_pkg;

  localparam int PIX_BITS   = 8;
  localparam int ROW_PIXELS = 5;
  localparam int ROW_BITS   = PIX_BITS * ROW_PIXELS;
  localparam int FUNC_BITS  = 2;
  localparam int VALUE_BITS = 11;
  localparam int VALUE_MAX  = 1020;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_GAUSS3 = 2'd0,
    FUNC_GAUSS5 = 2'd1,
    FUNC_GRAD_X = 2'd2,
    FUNC_GRAD_Y = 2'd3
  } func_t;

  typedef logic [ROW_BITS-1:0]          row_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    row_t                 row_top2;
    row_t                 row_top1;
    row_t                 row_mid;
    row_t                 row_bot1;
    row_t                 row_bot2;
  } window_t;

endpackage
`default_nettype wire

### src/gsw_if.sv
// valid / ready channels for windows in and filtered values out
`default_nettype none
interface gsw_win_if;
  logic                          valid;
  logic                          ready;
  logic [gsw_pkg::FUNC_BITS-1:0] func;
  gsw_pkg::row_t                 row_top2;
  gsw_pkg::row_t                 row_top1;
  gsw_pkg::row_t                 row_mid;
  gsw_pkg::row_t                 row_bot1;
  gsw_pkg::row_t                 row_bot2;

  modport source (
    output valid, func, row_top2, row_top1, row_mid, row_bot1, row_bot2,
    input  ready
  );
  modport sink (
    input  valid, func, row_top2, row_top1, row_mid, row_bot1, row_bot2,
    output ready
  );
endinterface

interface gsw_res_if;
  logic            valid;
  logic            ready;
  gsw_pkg::value_t value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface
`default_nettype wire

### src/gsw_kernel.sv
// kernel arithmetic: weighted sums for the gaussian and sobel modes
`default_nettype none
module gsw_kernel (
  input  gsw_pkg::window_t win,
  output gsw_pkg::value_t  value
);
  import gsw_pkg::*;

  function automatic logic [PIX_BITS-1:0] pix(input row_t row, input int col);
    pix = row[col*PIX_BITS +: PIX_BITS];
  endfunction

  // (1 2 1) over the inner three columns, max 4*255
  function automatic logic [PIX_BITS+1:0] r121(input row_t row);
    r121 = {2'b00, pix(row, 1)} + {1'b0, pix(row, 2), 1'b0} + {2'b00, pix(row, 3)};
  endfunction

  // (1 4 6 4 1) over all five columns, max 16*255
  function automatic logic [PIX_BITS+3:0] r14641(input row_t row);
    r14641 = {4'b0000, pix(row, 0)} + {2'b00, pix(row, 1), 2'b00}
           + {2'b00, pix(row, 2), 2'b00} + {3'b000, pix(row, 2), 1'b0}
           + {2'b00, pix(row, 3), 2'b00} + {4'b0000, pix(row, 4)};
  endfunction

  // (1 2 1) down one column of the inner 3x3
  function automatic logic [PIX_BITS+1:0] c121(input window_t w, input int col);
    c121 = {2'b00, pix(w.row_top1, col)} + {1'b0, pix(w.row_mid, col), 1'b0}
         + {2'b00, pix(w.row_bot1, col)};
  endfunction

  logic [PIX_BITS+1:0] t1_sum, mid_sum, b1_sum, left_sum, right_sum;
  logic [PIX_BITS+3:0] g3_sum;
  logic [PIX_BITS+3:0] f_t2, f_t1, f_mid, f_b1, f_b2;
  logic [PIX_BITS+7:0] g5_sum;
  value_t              grad_x, grad_y;

  always_comb begin
    t1_sum    = r121(win.row_top1);
    mid_sum   = r121(win.row_mid);
    b1_sum    = r121(win.row_bot1);
    left_sum  = c121(win, 1);
    right_sum = c121(win, 3);
    g3_sum    = {2'b00, t1_sum} + {1'b0, mid_sum, 1'b0} + {2'b00, b1_sum};

    f_t2  = r14641(win.row_top2);
    f_t1  = r14641(win.row_top1);
    f_mid = r14641(win.row_mid);
    f_b1  = r14641(win.row_bot1);
    f_b2  = r14641(win.row_bot2);
    g5_sum = {4'b0000, f_t2} + {2'b00, f_t1, 2'b00}
           + {2'b00, f_mid, 2'b00} + {3'b000, f_mid, 1'b0}
           + {2'b00, f_b1, 2'b00} + {4'b0000, f_b2};

    grad_x = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
    grad_y = $signed({1'b0, t1_sum}) - $signed({1'b0, b1_sum});

    case (func_t'(win.func))
      FUNC_GAUSS3: value = {3'b000, g3_sum[PIX_BITS+3:4]};
      FUNC_GAUSS5: value = {3'b000, g5_sum[PIX_BITS+7:8]};
      FUNC_GRAD_X: value = grad_x;
      FUNC_GRAD_Y: value = grad_y;
      default:     value = '0;
    endcase
  end

endmodule
`default_nettype wire

### src/gauss_sobel_window_filter.sv
// top level: registered window stage, kernel logic and registered result stage
//
// the caller gathers a 5x5 window of 8-bit gray pixels and a kernel select
// (gaussian 3x3, gaussian 5x5, x gradient, y gradient) and presents them as
// one transfer on win; one filtered value comes back as one transfer on res
// gaussian modes give 0..255, gradient modes a signed value in -1020..1020
//
// after a win transfer the window is registered, the kernel sums are pure logic,
// and the value is registered in the result stage, which raises res valid; a
// full result stage holds the window in the window stage until it drains
// throughput is one window per clock while res does not stall, set by the two
// register stages that each refill in the cycle they drain
//
// when res is stalled the result is held and the window stage still takes one
// more transfer; win.ready drops only when both stages are full
// rst is synchronous and empties both stages; no state survives between items
`default_nettype none
module gauss_sobel_window_filter (
  input  logic       clk,
  input  logic       rst,
  gsw_win_if.sink    win,
  gsw_res_if.source  res
);
  import gsw_pkg::*;

  logic    s1_valid;
  window_t s1_win;
  logic    s2_valid;
  value_t  s2_value;
  value_t  kernel_value;
  logic    s2_free;

  assign s2_free   = !s2_valid || res.ready;
  assign win.ready = !s1_valid || s2_free;
  assign res.valid = s2_valid;
  assign res.value = s2_value;

  gsw_kernel u_kernel (
    .win   (s1_win),
    .value (kernel_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (win.ready) begin
        s1_valid <= win.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win.valid && win.ready) begin
      s1_win <= '{func: win.func, row_top2: win.row_top2, row_top1: win.row_top1,
                  row_mid: win.row_mid, row_bot1: win.row_bot1,
                  row_bot2: win.row_bot2};
    end
    if (s2_free && s1_valid) begin
      s2_value <= kernel_value;
    end
  end

endmodule
`default_nettype wire

### src/gsw_checker.sv
// port-level checks on the window filter, bound to the top level
`default_nettype none
module gsw_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input gsw_pkg::value_t value
);
  import gsw_pkg::*;

  localparam value_t VMAX = value_t'(VALUE_MAX);
  localparam value_t VMIN = value_t'(-VALUE_MAX);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value))
    else $error("result dropped or changed while stalled");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("result missing two cycles after transfer");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (value <= VMAX) && (value >= VMIN))
    else $error("result out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind gauss_sobel_window_filter gsw_checker u_gsw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (win.valid),
  .in_ready  (win.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .value     (res.value)
);
`default_nettype wire

### bench/tb_gauss_sobel_window_filter.sv
// self-checking testbench for the gaussian / sobel window filter
module tb_gauss_sobel_window_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import gsw_pkg::*;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 376;

  typedef enum int {
    PAT_ZERO, PAT_FULL, PAT_RING, PAT_CENTRE, PAT_CHECKER,
    PAT_LEFT, PAT_RIGHT, PAT_TOP, PAT_BOTTOM
  } pattern_t;
  typedef enum int {TEX_UNIFORM, TEX_EXTREME, TEX_SMOOTH} texture_t;
  typedef logic [PIX_BITS-1:0] pixel_t;
  typedef pixel_t patch_t [ROW_PIXELS][ROW_PIXELS];

  logic clk;
  logic rst;

  gsw_win_if win_bus ();
  gsw_res_if res_bus ();

  gauss_sobel_window_filter DUT (
    .clk (clk),
    .rst (rst),
    .win (win_bus),
    .res (res_bus)
  );

  window_t window_q[$];
  value_t  expected_value_q[$];
  int      error_count;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      stall_cycles;
  int      hold_left;
  bit      hold_req;
  bit      hold_seen;
  logic    win_fire;

  function automatic int tap3(int i);
    return (i == 1) ? 2 : 1;
  endfunction

  function automatic int tap5(int i);
    case (i)
      0, 4:    return 1;
      1, 3:    return 4;
      default: return 6;
    endcase
  endfunction

  function automatic window_t pack_window(func_t f, patch_t px);
    window_t w;
    row_t    rows[ROW_PIXELS];
    for (int r = 0; r < ROW_PIXELS; r++) begin
      for (int c = 0; c < ROW_PIXELS; c++) begin
        rows[r][c*PIX_BITS +: PIX_BITS] = px[r][c];
      end
    end
    w.func     = f;
    w.row_top2 = rows[0];
    w.row_top1 = rows[1];
    w.row_mid  = rows[2];
    w.row_bot1 = rows[3];
    w.row_bot2 = rows[4];
    return w;
  endfunction

  function automatic value_t filter_value(window_t w);
    row_t rows[ROW_PIXELS];
    int   px[ROW_PIXELS][ROW_PIXELS];
    int   acc;
    rows[0] = w.row_top2;
    rows[1] = w.row_top1;
    rows[2] = w.row_mid;
    rows[3] = w.row_bot1;
    rows[4] = w.row_bot2;
    for (int r = 0; r < ROW_PIXELS; r++) begin
      for (int c = 0; c < ROW_PIXELS; c++) begin
        px[r][c] = int'(rows[r][c*PIX_BITS +: PIX_BITS]);
      end
    end
    acc = 0;
    case (func_t'(w.func))
      FUNC_GAUSS3: begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            acc += tap3(r) * tap3(c) * px[r+1][c+1];
          end
        end
        acc = acc >>> 4;
      end
      FUNC_GAUSS5: begin
        for (int r = 0; r < ROW_PIXELS; r++) begin
          for (int c = 0; c < ROW_PIXELS; c++) begin
            acc += tap5(r) * tap5(c) * px[r][c];
          end
        end
        acc = acc >>> 8;
      end
      FUNC_GRAD_X: begin
        for (int r = 0; r < 3; r++) begin
          acc += tap3(r) * (px[r+1][1] - px[r+1][3]);
        end
      end
      default: begin
        for (int c = 0; c < 3; c++) begin
          acc += tap3(c) * (px[1][c+1] - px[3][c+1]);
        end
      end
    endcase
    return acc[VALUE_BITS-1:0];
  endfunction

  task automatic queue_random(int count);
    patch_t   px;
    texture_t tex;
    pixel_t   base;
    for (int n = 0; n < count; n++) begin
      tex  = texture_t'($urandom_range(2));
      base = pixel_t'($urandom);
      for (int r = 0; r < ROW_PIXELS; r++) begin
        for (int c = 0; c < ROW_PIXELS; c++) begin
          case (tex)
            TEX_UNIFORM: px[r][c] = pixel_t'($urandom);
            TEX_EXTREME: px[r][c] = $urandom_range(1) ? '1 : '0;
            default:     px[r][c] = base + pixel_t'($urandom_range(6)) - pixel_t'(3);
          endcase
        end
      end
      window_q.push_back(pack_window(func_t'($urandom_range(3)), px));
    end
  endtask

  task automatic wait_drained();
    while (window_q.size() != 0 || win_bus.valid || expected_value_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // window source
  always @(negedge clk) begin : drive_windows
    window_t w;
    if (rst) begin
      win_bus.valid <= 1'b0;
    end else if (!win_bus.valid || win_fire) begin
      if (window_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = window_q.pop_front();
        win_bus.func     <= w.func;
        win_bus.row_top2 <= w.row_top2;
        win_bus.row_top1 <= w.row_top1;
        win_bus.row_mid  <= w.row_mid;
        win_bus.row_bot1 <= w.row_bot1;
        win_bus.row_bot2 <= w.row_bot2;
        win_bus.valid    <= 1'b1;
      end else begin
        win_bus.valid <= 1'b0;
      end
    end
  end

  // result sink, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      res_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    value_t got;
    value_t want;
    if (rst) begin
      win_fire <= 1'b0;
    end else begin
      win_fire <= win_bus.valid && win_bus.ready;
      if (win_bus.valid && win_bus.ready) begin
        expected_value_q.push_back(filter_value(window_t'({win_bus.func, win_bus.row_top2,
            win_bus.row_top1, win_bus.row_mid, win_bus.row_bot1, win_bus.row_bot2})));
      end
      if (res_bus.valid && res_bus.ready) begin
        got = res_bus.value;
        if (expected_value_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got %0d", $time, got);
          error_count++;
        end else begin
          want = expected_value_q.pop_front();
          if (got !== want) begin
            $display("%0t: value mismatch, expected %0d got %0d", $time, want, got);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (win_bus.valid && win_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("gauss_sobel_window_filter regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    patch_t   px;
    pattern_t pat;
    bit       keep;
    rst              = 1'b1;
    error_count      = 0;
    stall_cycles     = 0;
    hold_left        = 0;
    hold_req         = 1'b0;
    hold_seen        = 1'b0;
    win_fire         = 1'b0;
    send_idle_pct    = 24;
    recv_idle_pct    = 54;
    win_bus.valid    = 1'b0;
    win_bus.func     = FUNC_GAUSS3;
    win_bus.row_top2 = '0;
    win_bus.row_top1 = '0;
    win_bus.row_mid  = '0;
    win_bus.row_bot1 = '0;
    win_bus.row_bot2 = '0;
    res_bus.ready    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // flat, ring-only, centre-only, checker and full-scale gradient windows
    for (int f = 0; f < 4; f++) begin
      for (int p = 0; p <= int'(PAT_BOTTOM); p++) begin
        pat  = pattern_t'(p);
        keep = pat inside {PAT_ZERO, PAT_FULL, PAT_RING, PAT_CHECKER} ||
               (pat inside {PAT_LEFT, PAT_RIGHT} && func_t'(f) == FUNC_GRAD_X) ||
               (pat inside {PAT_TOP, PAT_BOTTOM} && func_t'(f) == FUNC_GRAD_Y) ||
               (pat == PAT_CENTRE && func_t'(f) inside {FUNC_GAUSS3, FUNC_GAUSS5});
        if (keep) begin
          for (int r = 0; r < ROW_PIXELS; r++) begin
            for (int c = 0; c < ROW_PIXELS; c++) begin
              case (pat)
                PAT_ZERO:    px[r][c] = '0;
                PAT_FULL:    px[r][c] = '1;
                PAT_RING:    px[r][c] = (r == 0 || r == 4 || c == 0 || c == 4) ? '1 : '0;
                PAT_CENTRE:  px[r][c] = (r == 2 && c == 2) ? '1 : '0;
                PAT_CHECKER: px[r][c] = ((r + c) % 2 == 1) ? '1 : '0;
                PAT_LEFT:    px[r][c] = (c < 2) ? '1 : '0;
                PAT_RIGHT:   px[r][c] = (c > 2) ? '1 : '0;
                PAT_TOP:     px[r][c] = (r < 2) ? '1 : '0;
                default:     px[r][c] = (r > 2) ? '1 : '0;
              endcase
            end
          end
          window_q.push_back(pack_window(func_t'(f), px));
        end
      end
    end
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 24;
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    // no idling, with one long result stall so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RANDOM_PER_PHASE);
    hold_req = ~hold_req;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_value_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_value_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("gauss_sobel_window_filter regression: pass");
    end else begin
      $display("gauss_sobel_window_filter regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
src/gsw_pkg.sv
src/gsw_if.sv
src/gsw_kernel.sv
src/gauss_sobel_window_filter.sv
src/gsw_checker.sv
bench/tb_gauss_sobel_window_filter.sv
